// ===== rtl/core/gic_pkg.sv =====
package gic_pkg;

  localparam int AxisMax    = 32767;
  localparam int TrigPress  = 26;
  localparam int DefRadius  = 7849;
  localparam int DefHold    = 10000000;
  localparam int DefTimeBits = 32;

  localparam logic [0:0] RegRadius = 1'b0;
  localparam logic [0:0] RegHold   = 1'b1;

  // per-lane result from the deadzone unit
  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
  } stick_res_t;

endpackage

// ===== rtl/core/gic_stick.sv =====
// one stick lane: magnitude root, then restoring divide for both axes
module gic_stick
  import gic_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic signed [15:0] ax_x,
  input  logic signed [15:0] ax_y,
  input  logic        [14:0] radius,
  output logic              done,
  output stick_res_t        res
);

  localparam logic [2:0] S_IDLE = 3'd0, S_SQRT = 3'd1, S_MUL = 3'd2,
                         S_DIVX = 3'd3, S_DIVY = 3'd4, S_DONE = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [5:0]  cnt_r;
  logic        negx_r, negy_r;
  logic [15:0] absx_r, absy_r;
  logic [31:0] s_r;
  logic [16:0] root_r;
  logic [33:0] rem_r;
  logic [14:0] rad_r;
  logic [47:0] den_r;
  logic [47:0] num_r;
  logic [47:0] prem_r;
  logic [15:0] quo_r;
  logic [15:0] qx_r;
  logic        zero_r;

  logic [33:0] trial;
  logic [16:0] mclamp;
  logic [15:0] mmr;
  logic [48:0] dshift;
  logic [48:0] dsub;
  logic        qbit;
  logic [31:0] abs_x_c, abs_y_c;
  logic [31:0] px, py;
  logic [47:0] nx, ny;

  always_comb begin
    abs_x_c = ax_x[15] ? 32'(-$signed({ax_x[15], ax_x})) : 32'(ax_x);
    abs_y_c = ax_y[15] ? 32'(-$signed({ax_y[15], ax_y})) : 32'(ax_y);
    trial   = {rem_r[31:0], s_r[31:30]} - {15'd0, root_r, 2'b01};
    mclamp  = (root_r > 17'(AxisMax)) ? 17'(AxisMax) : root_r;
    mmr     = 16'(mclamp - {2'b0, rad_r});
    dshift  = {prem_r, num_r[47]};
    qbit    = (dshift >= {1'b0, den_r});
    dsub    = dshift - {1'b0, den_r};
    px      = 32'(absx_r) * 32'(mmr);
    py      = 32'(absy_r) * 32'(mmr);
    // times AxisMax as shift and subtract
    nx      = {1'b0, px, 15'd0} - 48'(px);
    ny      = {1'b0, py, 15'd0} - 48'(py);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_SQRT;
      S_SQRT: if (cnt_r == 6'd15) state_nxt = zero_r ? S_DONE : S_MUL;
      S_MUL:  state_nxt = S_DIVX;
      S_DIVX: if (cnt_r == 6'd47) state_nxt = S_DIVY;
      S_DIVY: if (cnt_r == 6'd47) state_nxt = S_DONE;
      S_DONE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // mag and axis products are small enough to fit 48-bit numerator
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: if (start) begin
        negx_r <= ax_x[15];
        negy_r <= ax_y[15];
        absx_r <= abs_x_c[15:0];
        absy_r <= abs_y_c[15:0];
        s_r    <= abs_x_c * abs_x_c + abs_y_c * abs_y_c;
        rad_r  <= radius;
        root_r <= '0;
        rem_r  <= '0;
        cnt_r  <= '0;
        zero_r <= (radius == 15'(AxisMax)) ||
                  (abs_x_c * abs_x_c + abs_y_c * abs_y_c <= 32'(radius) * 32'(radius));
      end
      S_SQRT: begin
        s_r <= {s_r[29:0], 2'b00};
        if (!trial[33]) begin
          rem_r  <= trial;
          root_r <= {root_r[15:0], 1'b1};
        end else begin
          rem_r  <= {rem_r[31:0], s_r[31:30]};
          root_r <= {root_r[15:0], 1'b0};
        end
        cnt_r <= cnt_r + 6'd1;
      end
      S_MUL: begin
        den_r  <= 48'(32'(root_r) * 32'(17'(AxisMax) - {2'b0, rad_r}));
        num_r  <= nx;
        prem_r <= '0;
        cnt_r  <= '0;
      end
      S_DIVX, S_DIVY: begin
        if (cnt_r == 6'd47) begin
          cnt_r  <= '0;
          prem_r <= '0;
          if (state_r == S_DIVX) begin
            qx_r  <= {num_r[14:0], qbit};
            num_r <= ny;
          end else begin
            quo_r <= {num_r[14:0], qbit};
          end
        end else begin
          prem_r <= qbit ? dsub[47:0] : dshift[47:0];
          num_r  <= {num_r[46:0], qbit};
          cnt_r  <= cnt_r + 6'd1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    done = (state_r == S_DONE);
    if (zero_r) begin
      res.out_x = '0;
      res.out_y = '0;
    end else begin
      res.out_x = negx_r ? -$signed(qx_r) : $signed(qx_r);
      res.out_y = negy_r ? -$signed(quo_r) : $signed(quo_r);
    end
  end

endmodule

// ===== rtl/core/gic_latch.sv =====
// toggle and combo latches, updated once per poll
module gic_latch
  import gic_pkg::*;
#(
  parameter int TIME_BITS = DefTimeBits
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        upd,
  input  logic [7:0]  lt,
  input  logic [7:0]  rt,
  input  logic [15:0] bw,
  input  logic [31:0] stamp,
  input  logic [31:0] hold,
  output logic [14:0] held,
  output logic [16:0] tog,
  output logic [3:0]  combo
);

  localparam int TW = (TIME_BITS < 32) ? TIME_BITS : 32;

  logic [16:0]   tog_r, was_r;
  logic [3:0]    ctog_r, cheld_r, cfired_r;
  logic [TW-1:0] start_r [4];
  logic [16:0]   pressed;
  logic [3:0]    memb;
  logic          back;
  logic [TW-1:0] now;

  always_comb begin
    held = {bw[10], bw[9], bw[8], bw[7], bw[6], bw[3], bw[2], bw[1], bw[0],
            bw[5], bw[4], bw[15], bw[14], bw[13], bw[12]};
    back = held[5];
    memb = {held[13], rt >= 8'(TrigPress), held[12], lt >= 8'(TrigPress)};
    pressed = {held, memb[2], memb[0]};
    now = stamp[TW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tog_r <= '0; was_r <= '0; ctog_r <= '0; cheld_r <= '0; cfired_r <= '0;
      for (int i = 0; i < 4; i++) start_r[i] <= '0;
    end else if (upd) begin
      tog_r <= tog_r ^ (pressed & ~was_r);
      was_r <= pressed;
      for (int i = 0; i < 4; i++) begin
        if (back && memb[i]) begin
          if (!cheld_r[i]) begin
            cheld_r[i]  <= 1'b1;
            cfired_r[i] <= 1'b0;
            start_r[i]  <= now;
          end else if (!cfired_r[i]) begin
            if (TIME_BITS >= 32 ? (32'(TW'(now - start_r[i])) >= hold)
                                : ((hold >> TW) == '0 &&
                                   TW'(now - start_r[i]) >= hold[TW-1:0])) begin
              ctog_r[i]   <= ~ctog_r[i];
              cfired_r[i] <= 1'b1;
            end
          end
        end else begin
          cheld_r[i]  <= 1'b0;
          cfired_r[i] <= 1'b0;
        end
      end
    end
  end

  assign tog   = tog_r;
  assign combo = ctog_r;

endmodule

// ===== rtl/core/gamepad_input_conditioner.sv =====
// results come sooner when both sticks are zeroed early, since those lanes skip the multiply and divides
// each stick lane: 16-step root, a multiply state, two 48-step divides, a done state
// one poll in flight at a time; both sticks run in parallel
// the next poll is taken the cycle after a result loads, while that result waits
// rst_n synchronous active low: latches clear, radius 7849, hold 10000000
module gamepad_input_conditioner
  import gic_pkg::*;
#(
  parameter int TIME_BITS = DefTimeBits
)(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // connected, left_x, left_y, right_x, right_y, left_trigger, right_trigger,
  // button_word, timestamp (pad to 136)
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // left_out_x, left_out_y, right_out_x, right_out_y, left_trigger_out,
  // right_trigger_out, buttons_held, toggle_latches, combo_latches (pad to 120)
  output logic [119:0] out_tdata,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  logic        busy_r, ov_r;
  logic [14:0] rad_r;
  logic [31:0] hold_r;
  logic [7:0]  lt_r, rt_r;
  logic [14:0] heldo_r;
  logic [1:0]  done_r;
  logic        conn;
  logic [7:0]  lt, rt;
  logic [15:0] bw;
  logic        take;
  logic        dl, dr;
  logic        lanes_done, fin;
  stick_res_t  rl, rr;
  logic [14:0] held;
  logic [16:0] tog;
  logic [3:0]  combo;
  logic [119:0] od_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == RegHold) ? hold_r : {17'd0, rad_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_r  <= 15'(DefRadius);
      hold_r <= 32'(DefHold);
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr == {RegRadius, 2'b00}) rad_r <= cfg_pwdata[14:0];
      else if (cfg_paddr == {RegHold, 2'b00}) hold_r <= cfg_pwdata;
    end
  end

  assign conn = in_tdata[0];
  assign lt   = conn ? in_tdata[72:65] : '0;
  assign rt   = conn ? in_tdata[80:73] : '0;
  assign bw   = conn ? in_tdata[96:81] : '0;
  assign in_tready = !busy_r;
  assign take = in_tvalid && in_tready;

  gic_stick u_left (
    .clk, .rst_n, .start(take),
    .ax_x(conn ? $signed(in_tdata[16:1]) : 16'sd0),
    .ax_y(conn ? $signed(in_tdata[32:17]) : 16'sd0),
    .radius(rad_r), .done(dl), .res(rl)
  );
  gic_stick u_right (
    .clk, .rst_n, .start(take),
    .ax_x(conn ? $signed(in_tdata[48:33]) : 16'sd0),
    .ax_y(conn ? $signed(in_tdata[64:49]) : 16'sd0),
    .radius(rad_r), .done(dr), .res(rr)
  );

  gic_latch #(.TIME_BITS(TIME_BITS)) u_latch (
    .clk, .rst_n, .upd(take), .lt, .rt, .bw, .stamp(in_tdata[128:97]),
    .hold(hold_r), .held, .tog, .combo
  );

  // merge: lane results hold until the next start, so wait for both lanes
  // and for the output register to be free
  assign lanes_done = &(done_r | {dr, dl});
  assign fin = busy_r && lanes_done && (!ov_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; ov_r <= 1'b0; done_r <= '0;
    end else begin
      ov_r <= fin || (ov_r && !out_tready);
      if (take) begin
        busy_r <= 1'b1; done_r <= '0;
        lt_r <= lt; rt_r <= rt; heldo_r <= held;
      end else if (busy_r) begin
        done_r <= done_r | {dr, dl};
        if (fin) begin
          busy_r <= 1'b0;
          od_r <= {4'd0, combo, tog, heldo_r, rt_r, lt_r,
                   rr.out_y, rr.out_x, rl.out_y, rl.out_x};
        end
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

endmodule

// ===== rtl/core/gic_checker.sv =====
module gic_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [119:0] out_tdata
);

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("second poll taken while busy");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:0] != 16'h8000) else $error("axis out of range");

endmodule

bind gamepad_input_conditioner gic_checker u_chk (.*);

// ===== bench/tb_gamepad_input_conditioner.sv =====
module tb_gamepad_input_conditioner;
  import gic_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1500000;
  localparam int DrainCycles = 150;
  localparam int HoldOffCycles = 600;
  localparam int HeldSrc [15] = '{12, 13, 14, 15, 4, 5, 0, 1, 2, 3, 6, 7, 8, 9, 10};

  // fields from the highest bit down, matching in_tdata
  typedef struct packed {
    logic [31:0]        ts;
    logic [15:0]        bw;
    logic [7:0]         rt;
    logic [7:0]         lt;
    logic signed [15:0] ry;
    logic signed [15:0] rx;
    logic signed [15:0] ly;
    logic signed [15:0] lx;
    logic               conn;
  } poll_t;

  // fields from the highest bit down, matching out_tdata
  typedef struct packed {
    logic [3:0]         combo;
    logic [16:0]        tgl;
    logic [14:0]        held;
    logic [7:0]         rto;
    logic [7:0]         lto;
    logic signed [15:0] roy;
    logic signed [15:0] rox;
    logic signed [15:0] loy;
    logic signed [15:0] lox;
  } pad_res_t;

  typedef struct {
    poll_t    p;
    bit       typed;
    pad_res_t r;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [119:0] out_tdata;
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  gamepad_input_conditioner u_dut (.*);

  always #4 clk = ~clk;

  // predictor state
  logic [14:0] radius_r;
  logic [31:0] hold_r;
  logic [16:0] latch_bits, prev_pressed;
  logic [3:0]  combo_lat, combo_on, combo_done;
  logic [31:0] hold_t0 [4];

  pad_res_t pad_expect_q [$];
  int n_err = 0, n_checked = 0, n_sent = 0, cyc = 0;
  int gap_pct = 0, stall_pct = 0;
  int hold_req = 0, hold_seen = 0, hold_cnt = 0;
  logic [31:0] ts_now = 0;
  logic [15:0] combo_pat = 0;
  dir_row_t dir_tab [$];

  function automatic longint unsigned root_floor(longint unsigned s);
    longint unsigned res = 0;
    for (int i = 16; i >= 0; i--)
      if ((res | (64'd1 << i)) * (res | (64'd1 << i)) <= s) res |= 64'd1 << i;
    return res;
  endfunction

  function automatic stick_res_t deadzone_scale(logic signed [15:0] x, logic signed [15:0] y,
                                                logic [14:0] r);
    stick_res_t o;
    longint unsigned ax, ay, s, len, m, den, qx, qy;
    o = '0;
    ax = x < 0 ? -longint'(x) : longint'(x);
    ay = y < 0 ? -longint'(y) : longint'(y);
    s = ax * ax + ay * ay;
    if (s <= longint'(r) * r || r >= AxisMax) return o;
    len = root_floor(s);
    m = len > AxisMax ? AxisMax : len;
    den = len * (AxisMax - r);
    qx = ax * (m - r) * AxisMax / den;
    qy = ay * (m - r) * AxisMax / den;
    o.out_x = x < 0 ? -qx[15:0] : qx[15:0];
    o.out_y = y < 0 ? -qy[15:0] : qy[15:0];
    return o;
  endfunction

  function automatic pad_res_t condition_poll(poll_t p);
    pad_res_t   r;
    stick_res_t ls, rs;
    logic [7:0]  lt, rt;
    logic [15:0] bw;
    logic [14:0] held;
    logic [16:0] pressed;
    logic [3:0]  memb;
    lt = p.conn ? p.lt : '0;
    rt = p.conn ? p.rt : '0;
    bw = p.conn ? p.bw : '0;
    ls = p.conn ? deadzone_scale(p.lx, p.ly, radius_r) : '0;
    rs = p.conn ? deadzone_scale(p.rx, p.ry, radius_r) : '0;
    for (int i = 0; i < 15; i++) held[i] = bw[HeldSrc[i]];
    memb = {held[13], rt >= TrigPress, held[12], lt >= TrigPress};
    for (int i = 0; i < 4; i++) begin
      if (held[5] && memb[i]) begin
        if (!combo_on[i]) begin
          combo_on[i] = 1'b1;
          combo_done[i] = 1'b0;
          hold_t0[i] = p.ts;
        end else if (!combo_done[i] && (p.ts - hold_t0[i]) >= hold_r) begin
          combo_lat[i] ^= 1'b1;
          combo_done[i] = 1'b1;
        end
      end else begin
        combo_on[i] = 1'b0;
        combo_done[i] = 1'b0;
      end
    end
    pressed = {held, rt >= TrigPress, lt >= TrigPress};
    latch_bits ^= pressed & ~prev_pressed;
    prev_pressed = pressed;
    r.lox = ls.out_x; r.loy = ls.out_y;
    r.rox = rs.out_x; r.roy = rs.out_y;
    r.lto = lt; r.rto = rt;
    r.held = held;
    r.tgl = latch_bits;
    r.combo = combo_lat;
    return r;
  endfunction

  function automatic poll_t mk_poll(bit c, int lx, int ly, int rx, int ry, int lt, int rt,
                                    int bw, logic [31:0] ts);
    poll_t p;
    p.conn = c; p.lx = 16'(lx); p.ly = 16'(ly); p.rx = 16'(rx); p.ry = 16'(ry);
    p.lt = 8'(lt); p.rt = 8'(rt); p.bw = 16'(bw); p.ts = ts;
    return p;
  endfunction

  function automatic dir_row_t row(poll_t p);
    dir_row_t d;
    d.p = p; d.typed = 0; d.r = '0;
    return d;
  endfunction

  function automatic dir_row_t row_exp(poll_t p, int lox, int loy, int rox, int roy, int lto,
                                       int rto, int held, int tgl, int combo);
    dir_row_t d;
    d.p = p; d.typed = 1;
    d.r.lox = 16'(lox); d.r.loy = 16'(loy); d.r.rox = 16'(rox); d.r.roy = 16'(roy);
    d.r.lto = 8'(lto); d.r.rto = 8'(rto); d.r.held = 15'(held); d.r.tgl = 17'(tgl);
    d.r.combo = 4'(combo);
    return d;
  endfunction

  function automatic logic signed [15:0] pick_axis();
    int k;
    k = $urandom_range(9);
    if (k < 4) return 16'($urandom);
    if (k < 6) case ($urandom_range(4))
      0: return 16'(-32768);
      1: return 16'(-32767);
      2: return 16'(32767);
      3: return 16'(0);
      default: return 16'($urandom_range(1) ? 1 : -1);
    endcase
    if (k < 8)
      return 16'((int'(radius_r) + $urandom_range(4) - 2) * ($urandom_range(1) ? 1 : -1));
    return 16'($urandom_range(2000) - 1000);
  endfunction

  function automatic poll_t rand_poll();
    poll_t p;
    logic [15:0] bw;
    if ($urandom_range(99) < 20)
      combo_pat = {6'b0, $urandom_range(1) ? 2'b00 : 2'($urandom), 2'b0,
                   $urandom_range(99) < 85, 5'b0};
    bw = 16'($urandom);
    if ($urandom_range(99) < 70) bw = (bw & 16'hFCDF) | combo_pat;
    if ($urandom_range(99) < 3) ts_now = $urandom;
    else ts_now += $urandom_range(0, hold_r > 64'd8 ? hold_r / 2 + 8 : 16);
    p.conn = $urandom_range(99) >= 8;
    p.lx = pick_axis(); p.ly = pick_axis(); p.rx = pick_axis(); p.ry = pick_axis();
    p.lt = 8'($urandom_range(1) ? $urandom_range(25) : $urandom_range(26, 255));
    p.rt = 8'($urandom_range(1) ? $urandom_range(25) : $urandom_range(26, 255));
    p.bw = bw;
    p.ts = ts_now;
    return p;
  endfunction

  task automatic send_poll(poll_t p, bit typed, pad_res_t r);
    pad_res_t pred;
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'b0, p};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pred = condition_poll(p);
    pad_expect_q.push_back(typed ? r : pred);
    n_sent++;
  endtask

  task automatic apb_write(logic [0:0] idx, logic [31:0] val);
    logic [31:0] want;
    cfg_psel <= 1'b1; cfg_pwrite <= 1'b1; cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00}; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_pwrite <= 1'b0; cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    want = idx == RegRadius ? {17'b0, val[14:0]} : val;
    if (cfg_prdata !== want) begin
      if (n_err < 10) $display("readback reg %0d: exp %h got %h", idx, want, cfg_prdata);
      n_err++;
    end
    cfg_psel <= 1'b0; cfg_penable <= 1'b0;
    if (idx == RegRadius) radius_r = val[14:0];
    else hold_r = val;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pad_expect_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic cmp(string nm, longint e, longint g, inout bit bad);
    if (e != g) begin
      if (n_err < 10) $display("beat %0d %s: exp %0d got %0d", n_checked, nm, e, g);
      bad = 1;
    end
  endtask

  always @(posedge clk) begin
    pad_res_t e, g;
    bit bad;
    if (rst_n && out_tvalid && out_tready) begin
      g = out_tdata[115:0];
      bad = 0;
      if (pad_expect_q.size() == 0) begin
        if (n_err < 10) $display("unexpected beat %h", g);
        n_err++;
      end else begin
        e = pad_expect_q.pop_front();
        cmp("left_out_x", e.lox, g.lox, bad);
        cmp("left_out_y", e.loy, g.loy, bad);
        cmp("right_out_x", e.rox, g.rox, bad);
        cmp("right_out_y", e.roy, g.roy, bad);
        cmp("left_trigger_out", e.lto, g.lto, bad);
        cmp("right_trigger_out", e.rto, g.rto, bad);
        cmp("buttons_held", e.held, g.held, bad);
        cmp("toggle_latches", e.tgl, g.tgl, bad);
        cmp("combo_latches", e.combo, g.combo, bad);
        if (bad) n_err++;
        n_checked++;
      end
    end
  end

  // receiver side, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_cnt <= HoldOffCycles;
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= $urandom_range(99) >= stall_pct;
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int radii [7] = '{7849, 0, 32766, 32767, 1, 12000, 0};
    logic [31:0] holds [7] = '{10000000, 0, 500, 1000, 32'hFFFFFFFF, 3000, 0};
    int counts [7] = '{250, 200, 200, 150, 150, 250, 230};
    radius_r = DefRadius; hold_r = DefHold;
    latch_bits = '0; prev_pressed = '0;
    combo_lat = '0; combo_on = '0; combo_done = '0;
    for (int i = 0; i < 4; i++) hold_t0[i] = '0;
    holds[6] = $urandom;
    radii[6] = $urandom_range(32767);

    dir_tab = '{
      row_exp(mk_poll(0, -5, 5, 9, -9, 255, 255, 16'hFFFF, 32'h0), 0, 0, 0, 0, 0, 0, 0, 0, 0),
      row_exp(mk_poll(1, 32767, 0, -32768, 0, 25, 25, 0, 1),
              32767, 0, -32767, 0, 25, 25, 0, 0, 0),
      row_exp(mk_poll(1, 100, -100, 0, 0, 255, 26, 0, 2), 0, 0, 0, 0, 255, 26, 0, 3, 0),
      row(mk_poll(1, -32768, -32768, 32767, 32767, 0, 0, 16'h0800, 3)),
      row(mk_poll(1, 7849, 0, 7850, 0, 0, 0, 16'hFFFF, 4)),
      row(mk_poll(1, 0, -32768, 23170, 23170, 0, 0, 16'h0000, 5)),
      row(mk_poll(1, 1, -1, -7849, 1, 0, 0, 16'hF7FF, 6)),
      row(mk_poll(1, 0, 0, 0, 0, 0, 0, 0, 7)),
      // all four combos held, firing once the hold time is met
      row(mk_poll(1, 0, 0, 0, 0, 255, 255, 16'h0320, 100)),
      row(mk_poll(1, 0, 0, 0, 0, 255, 255, 16'h0320, 5000100)),
      row(mk_poll(1, 0, 0, 0, 0, 255, 255, 16'h0320, 10000100)),
      row(mk_poll(1, 0, 0, 0, 0, 255, 255, 16'h0320, 20000000)),
      row(mk_poll(1, 0, 0, 0, 0, 0, 0, 0, 20000001)),
      // timestamp wraps during the hold
      row(mk_poll(1, 0, 0, 0, 0, 0, 0, 16'h0120, 32'hFFFFFF00)),
      row(mk_poll(1, 0, 0, 0, 0, 0, 0, 16'h0120, 32'h00989600)),
      row(mk_poll(0, 300, 300, -300, 9000, 200, 200, 16'h0320, 32'h00989601)),
      row(mk_poll(1, -20000, 20000, 32767, -32768, 26, 25, 16'h0220, 32'h00989602)),
      row(mk_poll(1, -20000, 20000, 32767, -32768, 26, 25, 16'h0220, 32'hFFFFFFFF))
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_poll(dir_tab[i].p, dir_tab[i].typed, dir_tab[i].r);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      apb_write(RegRadius, radii[ph]);
      apb_write(RegHold, holds[ph]);
      case (ph % 4)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 75; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 75; end
        default: begin gap_pct = 22; stall_pct = 22; end
      endcase
      if (ph == 0) hold_req++;
      for (int k = 0; k < counts[ph]; k++) send_poll(rand_poll(), 0, '0);
      drain();
    end

    $display("polls sent %0d, results checked %0d over seven register settings", n_sent,
             n_checked);
    $display("covered disconnect, stick extremes, deadzone edge, combos and timestamp wrap");
    if (n_err == 0 && pad_expect_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", n_err, pad_expect_q.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
